// File: rtl/chs_pkg.sv
package chs_pkg;

  localparam int DEF_BUCKETS = 256;
  localparam int DEF_NODES   = 1024;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int FUNC_W      = 2;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic head_ld;
    logic hit_ld;
    logic step;
    logic free_rd;
    logic free_pop;
    logic bump;
    logic ins_new;
    logic ins_upd;
    logic set_full;
    logic unlink;
    logic push_free;
    logic clr_wr;
    logic emit;
  } chs_cmd_t;

  typedef struct packed {
    logic             mod_done;
    logic             cur_nil;
    logic             key_eq;
    logic             free_nil;
    logic             alloc_full;
    logic             hit;
    logic             clr_last;
    logic             out_busy;
    logic [FUNC_W-1:0] func;
  } chs_stat_t;

endpackage

// File: rtl/chs_if.sv
interface chs_req_if;
  logic                       valid;
  logic                       ready;
  logic [chs_pkg::FUNC_W-1:0] func;
  logic [chs_pkg::KEY_W-1:0]  key;
  logic [chs_pkg::VAL_W-1:0]  value;
  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface chs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [chs_pkg::VAL_W-1:0] read_value;
  logic                      pool_full;
  modport source (output valid, hit, read_value, pool_full, input ready);
  modport sink   (input valid, hit, read_value, pool_full, output ready);
endinterface

// File: rtl/chs_ram.sv
module chs_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/chs_dp.sv
module chs_dp #(
  parameter int BUCKETS = chs_pkg::DEF_BUCKETS,
  parameter int NODES   = chs_pkg::DEF_NODES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  chs_pkg::chs_cmd_t           cmd,
  output chs_pkg::chs_stat_t          stat,
  input  logic [chs_pkg::FUNC_W-1:0]  in_func,
  input  logic [chs_pkg::KEY_W-1:0]   in_key,
  input  logic [chs_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [chs_pkg::VAL_W-1:0]   out_read_value,
  output logic                        out_pool_full
);
  localparam int PW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam int BW = $clog2(BUCKETS);
  localparam logic [PW-1:0] NIL = PW'(NODES);
  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic [chs_pkg::FUNC_W-1:0] func_r;
  logic [chs_pkg::KEY_W-1:0]  key_r;
  logic [chs_pkg::VAL_W-1:0]  val_r, rdat_r;
  logic [PW-1:0] cur_r, prev_r, head_r, nlink_r, free_r, alloc_r;
  logic [AW-1:0] newn_r;
  logic [BW-1:0] clr_r, bkt;
  logic          hit_r, full_r, out_valid_r;
  logic          mod_done;

  logic [PW-1:0]            head_q, link_q;
  logic [chs_pkg::KEY_W-1:0] key_q;
  logic [chs_pkg::VAL_W-1:0] data_q;

  generate
    if (POW2) begin : g_mask
      assign bkt      = key_r[BW-1:0];
      assign mod_done = 1'b1;
    end else begin : g_recip
      // quotient by reciprocal multiply, then remainder by multiply and subtract
      localparam int KW = chs_pkg::KEY_W;
      localparam int RS = KW + BW;
      localparam logic [KW:0] RECIP =
        (KW+1)'(((64'd1 << RS) + 64'(BUCKETS - 1)) / 64'(BUCKETS));
      logic [BW-1:0] rem_r;
      logic [KW-1:0] quo_r;
      logic [1:0]    cnt_r;
      logic [2*KW:0] prod;
      logic [KW-1:0] diff;
      always_comb begin
        prod = (2*KW+1)'(key_r) * (2*KW+1)'(RECIP);
        diff = key_r - KW'(quo_r * KW'(BUCKETS));
      end
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          cnt_r <= '0;
        end else if (cmd.mod_step) begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd0) begin
            quo_r <= KW'(prod >> RS);
          end else begin
            rem_r <= diff[BW-1:0];
          end
        end
      end
      assign bkt      = rem_r;
      assign mod_done = cnt_r == 2'd2;
    end
  endgenerate

  logic          bk_we;
  logic [BW-1:0] bk_wa;
  logic [PW-1:0] bk_wd;
  logic          nk_we, nd_we, nl_we;
  logic [AW-1:0] nd_wa, nl_wa, n_ra;
  logic [PW-1:0] nl_wd;

  always_comb begin
    bk_we = 1'b0;
    bk_wa = bkt;
    bk_wd = NIL;
    nk_we = cmd.ins_new;
    nd_we = cmd.ins_new | cmd.ins_upd;
    nd_wa = cmd.ins_new ? newn_r : cur_r[AW-1:0];
    nl_we = 1'b0;
    nl_wa = newn_r;
    nl_wd = head_r;
    n_ra  = cmd.free_rd ? free_r[AW-1:0] : cur_r[AW-1:0];
    if (cmd.clr_wr) begin
      bk_we = 1'b1;
      bk_wa = clr_r;
    end
    if (cmd.ins_new) begin
      bk_we = 1'b1;
      bk_wd = PW'(newn_r);
      nl_we = 1'b1;
    end
    if (cmd.unlink) begin
      if (prev_r != NIL) begin
        nl_we = 1'b1;
        nl_wa = prev_r[AW-1:0];
        nl_wd = nlink_r;
      end else begin
        bk_we = 1'b1;
        bk_wd = nlink_r;
      end
    end
    if (cmd.push_free) begin
      nl_we = 1'b1;
      nl_wa = cur_r[AW-1:0];
      nl_wd = free_r;
    end
  end

  chs_ram #(.W(PW), .D(BUCKETS)) u_head (
    .clk, .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bkt), .rdata(head_q)
  );
  chs_ram #(.W(chs_pkg::KEY_W), .D(NODES)) u_key (
    .clk, .we(nk_we), .waddr(newn_r), .wdata(key_r), .raddr(n_ra), .rdata(key_q)
  );
  chs_ram #(.W(chs_pkg::VAL_W), .D(NODES)) u_data (
    .clk, .we(nd_we), .waddr(nd_wa), .wdata(val_r), .raddr(n_ra), .rdata(data_q)
  );
  chs_ram #(.W(PW), .D(NODES)) u_link (
    .clk, .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(n_ra), .rdata(link_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_key;
      val_r  <= in_value;
      rdat_r <= '0;
      hit_r  <= 1'b0;
      full_r <= 1'b0;
    end
    if (cmd.head_ld) begin
      cur_r  <= head_q;
      head_r <= head_q;
      prev_r <= NIL;
    end
    if (cmd.step) begin
      prev_r <= cur_r;
      cur_r  <= link_q;
    end
    if (cmd.hit_ld) begin
      hit_r   <= 1'b1;
      nlink_r <= link_q;
      rdat_r  <= data_q;
    end
    if (cmd.free_pop) begin
      newn_r <= free_r[AW-1:0];
    end
    if (cmd.bump) begin
      newn_r <= alloc_r[AW-1:0];
    end
    if (cmd.set_full) begin
      full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= NIL;
      alloc_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + BW'(1);
      end
      if (cmd.free_pop) begin
        free_r <= link_q;
      end
      if (cmd.push_free) begin
        free_r <= cur_r;
      end
      if (cmd.bump) begin
        alloc_r <= alloc_r + PW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit        <= hit_r;
      out_read_value <= (func_r == chs_pkg::FN_FIND) ? rdat_r : '0;
      out_pool_full  <= full_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.mod_done   = mod_done;
    stat.cur_nil    = cur_r == NIL;
    stat.key_eq     = key_q == key_r;
    stat.free_nil   = free_r == NIL;
    stat.alloc_full = alloc_r == NIL;
    stat.hit        = hit_r;
    stat.clr_last   = clr_r == BW'(BUCKETS - 1);
    stat.out_busy   = out_valid_r;
    stat.func       = func_r;
  end

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_r <= NIL) else $error("bump mark past pool");
  a_bump_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bump |-> alloc_r < NIL) else $error("bump with pool spent");
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !hit_r && !full_r) else $error("stale flags after load");
  a_new_nofull: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_new |-> !full_r && !hit_r) else $error("link on full or hit");
endmodule

// File: rtl/chs_ctrl.sv
module chs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chs_pkg::chs_stat_t stat,
  output chs_pkg::chs_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_HRD, S_HWT, S_NRD, S_NWT, S_ACT,
    S_FRD, S_FWT, S_INS, S_PSH, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.func != chs_pkg::FN_INSERT && stat.func != chs_pkg::FN_FIND &&
            stat.func != chs_pkg::FN_DELETE) begin
          state_nxt = S_DONE;
        end else if (stat.mod_done) begin
          state_nxt = S_HRD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_HRD: state_nxt = S_HWT;
      S_HWT: begin
        cmd.head_ld = 1'b1;
        state_nxt   = S_NRD;
      end
      S_NRD: state_nxt = stat.cur_nil ? S_ACT : S_NWT;
      S_NWT: begin
        if (stat.key_eq) begin
          cmd.hit_ld = 1'b1;
          state_nxt  = S_ACT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_NRD;
        end
      end
      S_ACT: begin
        state_nxt = S_DONE;
        priority if (stat.func == chs_pkg::FN_INSERT && stat.hit) begin
          cmd.ins_upd = 1'b1;
        end else if (stat.func == chs_pkg::FN_INSERT) begin
          priority if (!stat.free_nil) begin
            cmd.free_rd = 1'b1;
            state_nxt   = S_FRD;
          end else if (!stat.alloc_full) begin
            cmd.bump  = 1'b1;
            state_nxt = S_INS;
          end else begin
            cmd.set_full = 1'b1;
          end
        end else if (stat.func == chs_pkg::FN_DELETE && stat.hit) begin
          cmd.unlink = 1'b1;
          state_nxt  = S_PSH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FRD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FWT;
      end
      S_FWT: begin
        cmd.free_pop = 1'b1;
        state_nxt    = S_INS;
      end
      S_INS: begin
        cmd.ins_new = 1'b1;
        state_nxt   = S_DONE;
      end
      S_PSH: begin
        cmd.push_free = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !cmd.emit) else $error("double result");
  a_no_load_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ready) else $error("ready during clear");
  a_ins_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_new |-> $past(cmd.free_pop) || $past(cmd.bump)) else $error("no node");
endmodule

// File: rtl/chained_hash_key_value_store_top.sv
// Sequence: after acceptance, the bucket index (a mask when BUCKETS is a power of two,
//   else a reciprocal multiply, then multiply and subtract), the head read, a read of each
//   chain node visited, any update, and a register for the result.
// Throughput: one request at a time, set by the chain walk through node memory.
// Reset: synchronous active-low; afterwards a clearing pass writes null into every bucket
//   head, with no request taken meanwhile. Pool and free list start empty.
module chained_hash_key_value_store_top #(
  parameter int BUCKETS = chs_pkg::DEF_BUCKETS,
  parameter int NODES   = chs_pkg::DEF_NODES
) (
  input logic     clk,
  input logic     rst_n,
  chs_req_if.sink   in_req,
  chs_rsp_if.source out_rsp
);
  chs_pkg::chs_cmd_t  cmd;
  chs_pkg::chs_stat_t stat;

  chs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_req.valid), .in_ready(in_req.ready), .stat, .cmd
  );

  chs_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_func(in_req.func), .in_key(in_req.key), .in_value(in_req.value),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_hit(out_rsp.hit),
    .out_read_value(out_rsp.read_value), .out_pool_full(out_rsp.pool_full)
  );
endmodule

// File: bench/tb_chained_hash_key_value_store_top.sv
module tb_chained_hash_key_value_store_top;

  localparam int NB = chs_pkg::DEF_BUCKETS;
  localparam int NN = chs_pkg::DEF_NODES;
  localparam int NIL = NN;
  localparam logic [chs_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int LIMIT = 20000000;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        pool_full;
  } kv_result_t;

  class kv_scoreboard;
    int          head[NB];
    logic [31:0] nkey[NN];
    logic [31:0] ndata[NN];
    int          nlink[NN];
    int          mark;
    int          free_top;
    kv_result_t  pending[$];
    int          errors;
    int          live;

    function new();
      foreach (head[i]) head[i] = NIL;
      mark = 0;
      free_top = NIL;
      errors = 0;
      live = 0;
    endfunction

    function void note_request(logic [chs_pkg::FUNC_W-1:0] fn, logic [31:0] k,
                               logic [31:0] v);
      kv_result_t r;
      int b, cur, prv, node, n, steps;
      r = '0;
      if (fn != FN_UNUSED) begin
        b = k % NB;
        cur = head[b];
        prv = NIL;
        node = NIL;
        steps = 0;
        while (cur < NIL && steps < NN) begin
          if (nkey[cur] == k) begin
            node = cur;
            break;
          end
          prv = cur;
          cur = nlink[cur];
          steps++;
        end
        r.hit = node < NIL;
        if (fn == chs_pkg::FN_INSERT) begin
          if (r.hit) ndata[node] = v;
          else begin
            n = NIL;
            if (free_top < NIL) begin
              n = free_top;
              free_top = nlink[n];
            end else if (mark < NN) begin
              n = mark;
              mark++;
            end
            if (n < NIL) begin
              nkey[n] = k;
              ndata[n] = v;
              nlink[n] = head[b];
              head[b] = n;
              live++;
            end else r.pool_full = 1'b1;
          end
        end else if (fn == chs_pkg::FN_FIND) begin
          if (r.hit) r.read_value = ndata[node];
        end else if (r.hit) begin
          if (prv < NIL) nlink[prv] = nlink[node];
          else head[b] = nlink[node];
          nlink[node] = free_top;
          free_top = node;
          live--;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(kv_result_t got);
      kv_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit || got.read_value !== exp.read_value ||
          got.pool_full !== exp.pool_full) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit=%0b val=%h full=%0b, got hit=%0b val=%h full=%0b",
                   exp.hit, exp.read_value, exp.pool_full,
                   got.hit, got.read_value, got.pool_full);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  chs_req_if in_req();
  chs_rsp_if out_rsp();

  chained_hash_key_value_store_top uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  kv_scoreboard sb = new();
  logic [31:0] keys_used[$];
  int hold_off = 0;
  bit fill_mode = 0;
  int cycles = 0;

  initial begin
    in_req.valid = 1'b0;
    in_req.func = chs_pkg::FN_INSERT;
    in_req.key = '0;
    in_req.value = '0;
    out_rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      sb.check_result('{out_rsp.hit, out_rsp.read_value, out_rsp.pool_full});
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int g;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if (fill_mode || $urandom_range(0, 3) == 0) g = 0;
      else g = short_or_long_gap();
      if (g > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_beat(logic [chs_pkg::FUNC_W-1:0] fn, logic [31:0] k, logic [31:0] v,
                           bit nogap);
    int g;
    g = nogap ? 0 : short_or_long_gap();
    if (g > 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func <= fn;
    in_req.key <= k;
    in_req.value <= v;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(fn, k, v);
    if (fn == chs_pkg::FN_INSERT) keys_used.push_back(k);
    @(negedge clk);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (keys_used.size() > 0 && r < 6)
      return keys_used[$urandom_range(0, keys_used.size() - 1)];
    if (r < 9) return ($urandom_range(0, 15) << 8) | $urandom_range(0, 7);
    return $urandom();
  endfunction

  function automatic logic [chs_pkg::FUNC_W-1:0] pick_func(int wi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return FN_UNUSED;
    if (r < wi) return chs_pkg::FN_INSERT;
    if (r < wi + (100 - wi) / 2) return chs_pkg::FN_FIND;
    return chs_pkg::FN_DELETE;
  endfunction

  initial begin
    int i;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_beat(chs_pkg::FN_FIND, 32'h0, 32'h0, 0);
    send_beat(chs_pkg::FN_INSERT, 32'h0, 32'hFFFF_FFFF, 0);
    send_beat(chs_pkg::FN_INSERT, 32'hFFFF_FFFF, 32'h0, 0);
    send_beat(chs_pkg::FN_INSERT, 32'h0000_0100, 32'hA5A5_5A5A, 0);
    send_beat(chs_pkg::FN_INSERT, 32'h0000_0200, 32'h5A5A_A5A5, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0, 32'h0, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0000_0100, 32'h0, 0);
    send_beat(chs_pkg::FN_FIND, 32'hFFFF_FFFF, 32'h1234, 0);
    send_beat(chs_pkg::FN_INSERT, 32'h0000_0100, 32'h1111_2222, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0000_0100, 32'h0, 0);
    send_beat(chs_pkg::FN_DELETE, 32'h0000_0100, 32'h0, 0);
    send_beat(chs_pkg::FN_DELETE, 32'h0000_0100, 32'h0, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0000_0200, 32'h0, 0);
    send_beat(chs_pkg::FN_DELETE, 32'h0, 32'h0, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0000_0300, 32'h0, 0);
    send_beat(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(chs_pkg::FN_INSERT, 32'h0000_0300, 32'hDEAD_BEEF, 0);
    send_beat(chs_pkg::FN_FIND, 32'h0000_0300, 32'h0, 0);
    drain();

    // fill-up: receiver stalls long while sender keeps offering
    hold_off = 300;
    @(negedge clk);
    for (i = 0; i < 40; i++) send_beat(chs_pkg::FN_INSERT, $urandom(), $urandom(), 1);
    drain();

    // random mix
    for (i = 0; i < 350; i++)
      send_beat(pick_func(45), pick_key(), $urandom(), 0);
    drain();

    // exhaust the pool, then churn near full
    fill_mode = 1;
    while (sb.live < NN + 5)
      if (sb.mark >= NN && sb.free_top == NIL) break;
      else send_beat(chs_pkg::FN_INSERT, $urandom(), $urandom(), 1);
    fill_mode = 0;
    for (i = 0; i < 10; i++) send_beat(chs_pkg::FN_INSERT, $urandom(), $urandom(), 0);
    for (i = 0; i < 350; i++)
      send_beat(pick_func(50), pick_key(), $urandom(), 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
